>>> rtl/otqd_pkg.sv
// shared types and codes for the ordered task queue dispatcher
package otqd_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int OUT_ID_W    = 16;
    localparam int CNT_OUT_W   = 5;
    localparam int LIM_W       = 5;
    localparam logic [LIM_W-1:0] LIM_RESET = 5'd3;

    // operation codes
    localparam logic [2:0] OP_ENQ      = 3'd0;
    localparam logic [2:0] OP_DEQ      = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_UP       = 3'd3;
    localparam logic [2:0] OP_DOWN     = 3'd4;
    localparam logic [2:0] OP_CONTAINS = 3'd5;
    localparam logic [2:0] OP_DISPATCH = 3'd6;

    // task states
    localparam logic [1:0] ST_QUEUED = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_PAUSED = 2'd2;

    // cell commands
    localparam logic [2:0] CMD_HOLD  = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_SHIFT = 3'd2;
    localparam logic [2:0] CMD_ROT   = 3'd3;
    localparam logic [2:0] CMD_UP    = 3'd4;
    localparam logic [2:0] CMD_DOWN  = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] head_st;
    } t_cell_ctl;

endpackage

>>> rtl/ordered_task_queue_dispatcher.sv
// Ordered task queue with a concurrency limit, built as a row of cells that rotate through the head.
// An item is taken while the block is idle, and a new one only once it is idle again. Id operations
// walk the queue once, entry by entry (each entry passes the head and goes back in at the tail,
// but a remove drops the match and up and down move it), and enqueue and dispatch walk it once,
// a successful remove once more, to start queued tasks, one start request per started entry. The
// status request follows; start and status requests wait while the output is stalled. Dequeue,
// a rejected enqueue and the unused op code go straight to the status request. The limit register
// is to be written only while the block is idle; the block does not enforce it. Zero acts as one.
module ordered_task_queue_dispatcher import otqd_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_op,
    input  logic [ID_BITS-1:0]   i_task_id,
    input  logic [1:0]           i_task_state,
    input  logic                 i_cfg_wr_en,
    input  logic [LIM_W-1:0]     i_cfg_wr_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [OUT_ID_W-1:0]  o_out_id,
    output logic [1:0]           o_out_state,
    output logic                 o_found,
    output logic                 o_full_error,
    output logic [CNT_OUT_W-1:0] o_active_count,
    output logic [CNT_OUT_W-1:0] o_queue_count,
    output logic                 o_last
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > LIM_W) ? CW : LIM_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [MW-1:0]      r_run, n_run;
    logic [CW-1:0]      r_left, n_left;
    logic [LIM_W-1:0]   r_lim;
    logic [2:0]         r_op, n_op;
    logic [ID_BITS-1:0] r_id, n_id;
    logic               r_hit, n_hit;
    logic               r_first, n_first;
    logic               r_full, n_full;
    logic [ID_BITS-1:0] r_oid, n_oid;
    logic [1:0]         r_ost, n_ost;

    logic                 r_ov;
    logic                 r_kind, r_found, r_ferr, r_last;
    logic [OUT_ID_W-1:0]  r_out_id;
    logic [1:0]           r_out_st;
    logic [CNT_OUT_W-1:0] r_act, r_qc;

    logic                 out_ld, out_free;
    logic                 e_kind, e_found, e_ferr, e_last;
    logic [OUT_ID_W-1:0]  e_id;
    logic [1:0]           e_st;
    logic [MW-1:0]        e_act;

    t_cell_ctl          ctl;
    logic [ID_BITS-1:0] c_id [DEPTH+2];
    logic [1:0]         c_st [DEPTH+2];
    logic [ID_BITS-1:0] head_id;
    logic [1:0]         head_st;
    logic [LIM_W-1:0]   lim;
    logic               head_match, can_start;

    assign c_id[DEPTH]   = '0;
    assign c_st[DEPTH]   = '0;
    assign c_id[DEPTH+1] = '0;
    assign c_st[DEPTH+1] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        otqd_cell #(.IDX(k), .ID_BITS(ID_BITS), .CW(CW)) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_count   (r_count),
            .i_new_id  (i_task_id),
            .i_new_st  (i_task_state),
            .i_head_id (c_id[0]),
            .i_sec_id  (c_id[1]),
            .i_sec_st  (c_st[1]),
            .i_nx1_id  (c_id[k+1]),
            .i_nx1_st  (c_st[k+1]),
            .i_nx2_id  (c_id[k+2]),
            .i_nx2_st  (c_st[k+2]),
            .i_head_st (c_st[0]),
            .o_id      (c_id[k]),
            .o_st      (c_st[k])
        );
    end

    assign head_id    = c_id[0];
    assign head_st    = c_st[0];
    assign lim        = (r_lim == '0) ? LIM_W'(1) : r_lim;
    assign head_match = (head_id == r_id);
    assign can_start  = (head_st == ST_QUEUED) && (MW'(r_run) < MW'(lim));
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_run   = r_run;
        n_left  = r_left;
        n_op    = r_op;
        n_id    = r_id;
        n_hit   = r_hit;
        n_first = r_first;
        n_full  = r_full;
        n_oid   = r_oid;
        n_ost   = r_ost;
        ctl.cmd     = CMD_HOLD;
        ctl.head_st = head_st;
        out_ld  = 1'b0;
        e_kind  = 1'b0;
        e_id    = '0;
        e_st    = '0;
        e_found = 1'b0;
        e_ferr  = 1'b0;
        e_act   = r_run;
        e_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_id    = i_task_id;
                    n_hit   = 1'b0;
                    n_first = 1'b1;
                    n_full  = 1'b0;
                    n_oid   = '0;
                    n_ost   = '0;
                    n_left  = r_count;
                    case (i_op)
                        OP_ENQ: begin
                            if (r_count == FULL_CNT) begin
                                n_full  = 1'b1;
                                n_state = S_STAT;
                            end else begin
                                ctl.cmd = CMD_LOAD;
                                n_count = r_count + CW'(1);
                                n_left  = r_count + CW'(1);
                                n_state = S_SCAN;
                            end
                        end
                        OP_DEQ: begin
                            if (r_count != '0) begin
                                ctl.cmd = CMD_SHIFT;
                                n_hit   = 1'b1;
                                n_oid   = head_id;
                                n_ost   = head_st;
                                n_count = r_count - CW'(1);
                            end
                            n_state = S_STAT;
                        end
                        OP_REMOVE, OP_UP, OP_DOWN, OP_CONTAINS: n_state = S_WALK;
                        OP_DISPATCH: n_state = S_SCAN;
                        default: n_state = S_STAT;
                    endcase
                end
            end
            S_WALK: begin
                if (r_left == '0) begin
                    if (r_op == OP_REMOVE && r_hit) begin
                        n_left  = r_count;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_STAT;
                    end
                end else begin
                    n_first = 1'b0;
                    ctl.cmd = CMD_ROT;
                    n_left  = r_left - CW'(1);
                    if (!r_hit && head_match) begin
                        case (r_op)
                            OP_REMOVE: begin
                                // drop the head: it is not written back at the tail
                                ctl.cmd = CMD_SHIFT;
                                n_hit   = 1'b1;
                                n_count = r_count - CW'(1);
                                if ((head_st == ST_ACTIVE || head_st == ST_PAUSED) &&
                                    r_run != '0) begin
                                    n_run = r_run - MW'(1);
                                end
                            end
                            OP_UP: begin
                                // the front entry cannot move up and is not a candidate
                                if (!r_first) begin
                                    ctl.cmd = CMD_UP;
                                    n_hit   = 1'b1;
                                end
                            end
                            OP_DOWN: begin
                                n_hit = 1'b1;
                                if (r_left >= CW'(2)) begin
                                    ctl.cmd = CMD_DOWN;
                                    n_left  = r_left - CW'(2);
                                end else begin
                                    n_hit = 1'b0;
                                end
                            end
                            OP_CONTAINS: n_hit = 1'b1;
                            default: n_hit = r_hit;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (r_left == '0) begin
                    n_state = S_STAT;
                end else if (can_start) begin
                    if (out_free) begin
                        ctl.cmd     = CMD_ROT;
                        ctl.head_st = ST_ACTIVE;
                        n_left  = r_left - CW'(1);
                        n_run   = r_run + MW'(1);
                        out_ld  = 1'b1;
                        e_id    = OUT_ID_W'(head_id);
                        e_st    = ST_ACTIVE;
                        e_act   = r_run + MW'(1);
                    end
                end else begin
                    ctl.cmd = CMD_ROT;
                    n_left  = r_left - CW'(1);
                end
            end
            S_STAT: begin
                if (out_free) begin
                    out_ld  = 1'b1;
                    e_kind  = 1'b1;
                    e_id    = OUT_ID_W'(r_oid);
                    e_st    = r_ost;
                    e_found = r_hit;
                    e_ferr  = r_full;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_run   <= '0;
            r_lim   <= LIM_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
            if (i_cfg_wr_en) begin
                r_lim <= i_cfg_wr_data;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_op    <= n_op;
        r_id    <= n_id;
        r_hit   <= n_hit;
        r_first <= n_first;
        r_full  <= n_full;
        r_oid   <= n_oid;
        r_ost   <= n_ost;
        if (out_ld) begin
            r_kind   <= e_kind;
            r_out_id <= e_id;
            r_out_st <= e_st;
            r_found  <= e_found;
            r_ferr   <= e_ferr;
            r_act    <= CNT_OUT_W'(e_act);
            r_qc     <= CNT_OUT_W'(r_count);
            r_last   <= e_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_out_id       = r_out_id;
    assign o_out_state    = r_out_st;
    assign o_found        = r_found;
    assign o_full_error   = r_ferr;
    assign o_active_count = r_act;
    assign o_queue_count  = r_qc;
    assign o_last         = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted request left the controller idle");

    a_status_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && out_free) |=> (r_ov && r_last && r_kind))
        else $error("status request not presented");

    a_start_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_kind) |-> (r_act != '0 && !r_last))
        else $error("start request with no active task");

endmodule

>>> rtl/otqd_cell.sv
// one queue slot: holds an entry and takes data from its neighbours
module otqd_cell import otqd_pkg::*; #(
    parameter int IDX     = 0,
    parameter int ID_BITS = ID_BITS_DEF,
    parameter int CW      = 5
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [ID_BITS-1:0] i_new_id,
    input  logic [1:0]         i_new_st,
    input  logic [ID_BITS-1:0] i_head_id,
    input  logic [ID_BITS-1:0] i_sec_id,
    input  logic [1:0]         i_sec_st,
    input  logic [ID_BITS-1:0] i_nx1_id,
    input  logic [1:0]         i_nx1_st,
    input  logic [ID_BITS-1:0] i_nx2_id,
    input  logic [1:0]         i_nx2_st,
    input  logic [1:0]         i_head_st,
    output logic [ID_BITS-1:0] o_id,
    output logic [1:0]         o_st
);
    localparam logic [CW:0] K0 = (CW+1)'(IDX);
    localparam logic [CW:0] K1 = (CW+1)'(IDX + 1);
    localparam logic [CW:0] K2 = (CW+1)'(IDX + 2);

    logic [ID_BITS-1:0] r_id, n_id;
    logic [1:0]         r_st, n_st;
    logic [CW:0]        cnt;
    logic               is_end, is_tail, is_pen;

    assign cnt     = {1'b0, i_count};
    assign is_end  = (cnt == K0);
    assign is_tail = (cnt == K1);
    assign is_pen  = (cnt == K2);

    always_comb begin
        n_id = r_id;
        n_st = r_st;
        case (i_ctl.cmd)
            CMD_LOAD: begin
                if (is_end) begin
                    n_id = i_new_id;
                    n_st = i_new_st;
                end
            end
            CMD_SHIFT: begin
                n_id = i_nx1_id;
                n_st = i_nx1_st;
            end
            CMD_ROT: begin
                if (is_tail) begin
                    n_id = i_head_id;
                    n_st = i_ctl.head_st;
                end else begin
                    n_id = i_nx1_id;
                    n_st = i_nx1_st;
                end
            end
            // matched head goes in ahead of the entry it overtakes
            CMD_UP: begin
                if (is_pen) begin
                    n_id = i_head_id;
                    n_st = i_head_st;
                end else if (!is_tail) begin
                    n_id = i_nx1_id;
                    n_st = i_nx1_st;
                end
            end
            // two steps at once, head and second swapped on the way to the tail
            CMD_DOWN: begin
                if (is_pen) begin
                    n_id = i_sec_id;
                    n_st = i_sec_st;
                end else if (is_tail) begin
                    n_id = i_head_id;
                    n_st = i_head_st;
                end else begin
                    n_id = i_nx2_id;
                    n_st = i_nx2_st;
                end
            end
            default: begin
                n_id = r_id;
                n_st = r_st;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        r_st <= n_st;
    end

    assign o_id = r_id;
    assign o_st = r_st;

endmodule
